>>> rtl/single_edit_variant_apply_check_unit_assert.svh
// Assertion macros for the single-edit variant unit.
// Needs clk and rst_n in the scope of the including module.
`ifndef SINGLE_EDIT_VARIANT_APPLY_CHECK_UNIT_ASSERT_SVH
`define SINGLE_EDIT_VARIANT_APPLY_CHECK_UNIT_ASSERT_SVH

// same-cycle implication
`define SVAC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SVAC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/svac_pkg.sv
// Shared types, codes and edit mapping functions for the single-edit variant unit.
// No dependencies.
package svac_pkg;

    localparam int POS_W           = 6;
    localparam int POS2_W          = 5;
    localparam int RES_W           = 5;
    localparam int KIND_W          = 3;
    localparam int LEN_W           = 7;
    localparam int DEF_MAX_SEQ_LEN = 32;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_EDIT = 2'd1,
        OP_EMIT = 2'd2,
        OP_CMP  = 2'd3
    } op_t;

    localparam logic [KIND_W-1:0] EK_SAME = 3'd0;
    localparam logic [KIND_W-1:0] EK_SUB  = 3'd1;
    localparam logic [KIND_W-1:0] EK_DEL  = 3'd2;
    localparam logic [KIND_W-1:0] EK_INS  = 3'd3;
    localparam logic [KIND_W-1:0] EK_DSUB = 3'd4;

    localparam logic RK_RESIDUE = 1'b0;
    localparam logic RK_VERDICT = 1'b1;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  pos1;
        logic [RES_W-1:0]  res1;
        logic [POS2_W-1:0] pos2;
        logic [RES_W-1:0]  res2;
    } edit_t;

    typedef struct packed {
        logic [LEN_W-1:0] seed_idx;
        logic             use_ovr;
        logic [RES_W-1:0] ovr_res;
    } map_t;

    // one request in flight between the read issue and the result register
    typedef struct packed {
        logic             is_cmp;
        logic [LEN_W-1:0] idx;
        logic [LEN_W-1:0] len;
        logic             last;
        logic             use_ovr;
        logic [RES_W-1:0] ovr_res;
        logic             in_range;
        logic [RES_W-1:0] cmp_res;
    } slot_t;

    function automatic logic [LEN_W-1:0] edited_len(logic [KIND_W-1:0] kind,
                                                    logic [POS_W-1:0] slen);
        logic [LEN_W-1:0] l;
        l = {1'b0, slen};
        case (kind)
            EK_DEL:  l = (slen != '0) ? l - LEN_W'(1) : '0;
            EK_INS:  l = l + LEN_W'(1);
            default: l = {1'b0, slen};
        endcase
        return l;
    endfunction

    // edited index -> seed index, or a residue taken from the descriptor
    function automatic map_t map_index(edit_t e, logic [LEN_W-1:0] i);
        map_t             m;
        logic [LEN_W-1:0] p1;
        logic [LEN_W-1:0] p2;
        p1        = {1'b0, e.pos1};
        p2        = {2'b00, e.pos2};
        m.seed_idx = i;
        m.use_ovr  = 1'b0;
        m.ovr_res  = '0;
        case (e.kind)
            EK_SUB:
            begin
                if (i == p1)
                begin
                    m.use_ovr = 1'b1;
                    m.ovr_res = e.res1;
                end
            end
            EK_DEL:
            begin
                if (i >= p1)
                    m.seed_idx = i + LEN_W'(1);
            end
            EK_INS:
            begin
                if (i == p1)
                begin
                    m.use_ovr = 1'b1;
                    m.ovr_res = e.res1;
                end
                else if (i > p1)
                    m.seed_idx = i - LEN_W'(1);
            end
            EK_DSUB:
            begin
                if (i == p2)
                begin
                    m.use_ovr = 1'b1;
                    m.ovr_res = e.res2;
                end
                else if (i == p1)
                begin
                    m.use_ovr = 1'b1;
                    m.ovr_res = e.res1;
                end
            end
            default:
            begin
                m.use_ovr = 1'b0;
            end
        endcase
        return m;
    endfunction

endpackage

>>> rtl/svac_seed_mem.sv
// Seed residue store: one write port, one read port with registered data.
// Depends on svac_pkg.
module svac_seed_mem #(
    parameter int DEPTH = svac_pkg::DEF_MAX_SEQ_LEN,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [svac_pkg::RES_W-1:0] wdata,
    input  logic                      re,
    input  logic [AW-1:0]             raddr,
    output logic [svac_pkg::RES_W-1:0] rd_data
);

    logic [svac_pkg::RES_W-1:0] mem [DEPTH];
    logic [svac_pkg::RES_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        // data holds while no read is issued, so a stalled request keeps it
        if (re)
            rd_data_reg <= mem[raddr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/svac_issue.sv
// Read issue: maps compare requests and the emit sweep onto seed reads.
// Depends on svac_pkg.
module svac_issue #(
    parameter int MAX_SEQ_LEN = svac_pkg::DEF_MAX_SEQ_LEN,
    localparam int AW         = $clog2(MAX_SEQ_LEN)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        cmp_req,
    input  logic [svac_pkg::POS_W-1:0]  cmp_pos,
    input  logic [svac_pkg::RES_W-1:0]  cmp_res,
    input  logic                        cmp_last,
    input  logic                        slot_free,
    input  svac_pkg::edit_t             desc,
    input  logic [svac_pkg::LEN_W-1:0]  elen,
    output logic                        busy,
    output logic                        iss_valid,
    output svac_pkg::slot_t             iss,
    output logic [AW-1:0]               rd_addr
);

    logic                       emitting_reg, emitting_next;
    logic [svac_pkg::LEN_W-1:0] idx_reg, idx_next;
    logic [svac_pkg::LEN_W-1:0] sel_idx;
    logic [svac_pkg::LEN_W-1:0] idx_inc;
    logic                       emit_fire;
    svac_pkg::map_t             map;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emitting_reg <= 1'b0;
            idx_reg      <= '0;
        end
        else
        begin
            emitting_reg <= emitting_next;
            idx_reg      <= idx_next;
        end
    end

    always_comb
    begin
        idx_inc       = idx_reg + svac_pkg::LEN_W'(1);
        emit_fire     = emitting_reg && slot_free && !cmp_req;
        emitting_next = emitting_reg;
        idx_next      = idx_reg;
        if (start)
        begin
            emitting_next = 1'b1;
            idx_next      = '0;
        end
        else if (emit_fire)
        begin
            idx_next = idx_inc;
            if (idx_inc == elen)
                emitting_next = 1'b0;
        end

        sel_idx  = cmp_req ? {1'b0, cmp_pos} : idx_reg;
        map      = svac_pkg::map_index(desc, sel_idx);
        rd_addr  = map.seed_idx[AW-1:0];

        iss_valid    = cmp_req || emit_fire;
        iss.is_cmp   = cmp_req;
        iss.idx      = sel_idx;
        iss.len      = elen;
        iss.last     = cmp_req ? cmp_last : (idx_inc == elen);
        iss.use_ovr  = map.use_ovr;
        iss.ovr_res  = map.ovr_res;
        iss.in_range = map.seed_idx < svac_pkg::LEN_W'(MAX_SEQ_LEN);
        iss.cmp_res  = cmp_res;
    end

    assign busy = emitting_reg;

endmodule

>>> rtl/single_edit_variant_apply_check_unit.sv
// Single-edit variant unit: holds a seed sequence and one edit (identical, substitution,
// deletion, insertion or double substitution). Load, set-edit and compare requests are
// taken one per cycle while no emit sweep runs and results flow; a compare request reads
// one seed residue, and its result (a verdict on the last residue of a candidate) passes
// the read stage register and then the output register. An emit request streams the
// edited sequence at one residue per cycle while the output is not stalled, and holds
// off further requests until its sweep over the single seed read port ends. A result waits
// in an output register, and the read in flight holds until that register frees.
// Depends on svac_pkg, svac_seed_mem, svac_issue and the assertion macro header.
`include "single_edit_variant_apply_check_unit_assert.svh"

module single_edit_variant_apply_check_unit #(
    parameter int MAX_SEQ_LEN = svac_pkg::DEF_MAX_SEQ_LEN
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   opcode,
    input  logic [svac_pkg::POS_W-1:0]   position,
    input  logic [svac_pkg::RES_W-1:0]   residue,
    input  logic                         last_flag,
    input  logic [svac_pkg::KIND_W-1:0]  edit_kind,
    input  logic [svac_pkg::POS_W-1:0]   first_position,
    input  logic [svac_pkg::RES_W-1:0]   first_residue,
    input  logic [svac_pkg::POS2_W-1:0]  second_position,
    input  logic [svac_pkg::RES_W-1:0]   second_residue,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         result_kind,
    output logic [svac_pkg::RES_W-1:0]   out_residue,
    output logic [svac_pkg::POS_W-1:0]   out_position,
    output logic [svac_pkg::POS_W-1:0]   out_length,
    output logic                         out_last,
    output logic                         matched
);

    localparam int AW = $clog2(MAX_SEQ_LEN);

    svac_pkg::op_t              op;
    logic                       accept;
    logic                       busy;
    logic                       advance;
    logic                       slot_free;
    logic                       iss_valid;
    svac_pkg::slot_t            iss;
    logic [AW-1:0]              rd_addr;
    logic [svac_pkg::RES_W-1:0] rd_data;
    logic [svac_pkg::LEN_W-1:0] elen;
    logic                       pos_in_store;

    logic [svac_pkg::POS_W-1:0] seed_len_reg, seed_len_next;
    svac_pkg::edit_t            desc_reg, desc_next;
    logic                       mismatch_reg, mismatch_next;
    logic [svac_pkg::POS_W-1:0] count_reg, count_next;
    logic                       s1_v_reg, s1_v_next;
    svac_pkg::slot_t            s1_reg, s1_next;

    logic                       out_valid_reg, out_valid_next;
    logic                       kind_reg, kind_next;
    logic [svac_pkg::RES_W-1:0] res_reg, res_next;
    logic [svac_pkg::POS_W-1:0] opos_reg, opos_next;
    logic [svac_pkg::POS_W-1:0] olen_reg, olen_next;
    logic                       olast_reg, olast_next;
    logic                       match_reg, match_next;

    logic [svac_pkg::RES_W-1:0] s1_res;
    logic                       s1_mis;
    logic                       s1_fire;

    assign op           = svac_pkg::op_t'(opcode);
    assign advance      = !out_valid_reg || out_ready;
    assign slot_free    = !s1_v_reg || advance;
    assign in_ready     = !busy && slot_free;
    assign accept       = in_valid && in_ready;
    assign elen         = svac_pkg::edited_len(desc_reg.kind, seed_len_reg);
    assign pos_in_store = {1'b0, position} < svac_pkg::LEN_W'(MAX_SEQ_LEN);

    svac_seed_mem #(
        .DEPTH (MAX_SEQ_LEN)
    ) u_mem (
        .clk     (clk),
        .we      (accept && op == svac_pkg::OP_LOAD && pos_in_store),
        .waddr   (position[AW-1:0]),
        .wdata   (residue),
        .re      (iss_valid),
        .raddr   (rd_addr),
        .rd_data (rd_data)
    );

    svac_issue #(
        .MAX_SEQ_LEN (MAX_SEQ_LEN)
    ) u_issue (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept && op == svac_pkg::OP_EMIT && elen != '0),
        .cmp_req   (accept && op == svac_pkg::OP_CMP),
        .cmp_pos   (position),
        .cmp_res   (residue),
        .cmp_last  (last_flag),
        .slot_free (slot_free),
        .desc      (desc_reg),
        .elen      (elen),
        .busy      (busy),
        .iss_valid (iss_valid),
        .iss       (iss),
        .rd_addr   (rd_addr)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_len_reg  <= '0;
            desc_reg      <= '0;
            mismatch_reg  <= 1'b0;
            count_reg     <= '0;
            s1_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seed_len_reg  <= seed_len_next;
            desc_reg      <= desc_next;
            mismatch_reg  <= mismatch_next;
            count_reg     <= count_next;
            s1_v_reg      <= s1_v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg    <= s1_next;
        kind_reg  <= kind_next;
        res_reg   <= res_next;
        opos_reg  <= opos_next;
        olen_reg  <= olen_next;
        olast_reg <= olast_next;
        match_reg <= match_next;
    end

    always_comb
    begin
        s1_res  = s1_reg.use_ovr ? s1_reg.ovr_res : (s1_reg.in_range ? rd_data : '0);
        s1_mis  = (s1_reg.idx != {1'b0, count_reg}) || (s1_reg.idx >= s1_reg.len)
               || (s1_reg.cmp_res != s1_res);
        s1_fire = s1_v_reg && advance;

        seed_len_next  = seed_len_reg;
        desc_next      = desc_reg;
        mismatch_next  = mismatch_reg;
        count_next     = count_reg;
        s1_v_next      = iss_valid ? 1'b1 : (advance ? 1'b0 : s1_v_reg);
        s1_next        = iss_valid ? iss : s1_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        kind_next      = kind_reg;
        res_next       = res_reg;
        opos_next      = opos_reg;
        olen_next      = olen_reg;
        olast_next     = olast_reg;
        match_next     = match_reg;

        if (s1_fire)
        begin
            if (!s1_reg.is_cmp)
            begin
                out_valid_next = 1'b1;
                kind_next      = svac_pkg::RK_RESIDUE;
                res_next       = s1_res;
                opos_next      = s1_reg.idx[svac_pkg::POS_W-1:0];
                olen_next      = s1_reg.len[svac_pkg::POS_W-1:0];
                olast_next     = s1_reg.last;
                match_next     = 1'b0;
            end
            else if (!s1_reg.last)
            begin
                mismatch_next = mismatch_reg || s1_mis;
                if (count_reg != '1)
                    count_next = count_reg + svac_pkg::POS_W'(1);
            end
            else
            begin
                out_valid_next = 1'b1;
                kind_next      = svac_pkg::RK_VERDICT;
                res_next       = '0;
                opos_next      = s1_reg.idx[svac_pkg::POS_W-1:0];
                olen_next      = s1_reg.len[svac_pkg::POS_W-1:0];
                olast_next     = 1'b1;
                match_next     = !(mismatch_reg || s1_mis)
                              && (s1_reg.idx + svac_pkg::LEN_W'(1) == s1_reg.len);
                mismatch_next  = 1'b0;
                count_next     = '0;
            end
        end

        // a request accepted here follows the one leaving the read stage
        if (accept)
        begin
            case (op)
                svac_pkg::OP_LOAD:
                begin
                    if (last_flag)
                        seed_len_next = pos_in_store ? position + svac_pkg::POS_W'(1)
                                                     : svac_pkg::POS_W'(MAX_SEQ_LEN);
                end
                svac_pkg::OP_EDIT:
                begin
                    desc_next.kind = edit_kind;
                    desc_next.pos1 = first_position;
                    desc_next.res1 = first_residue;
                    desc_next.pos2 = second_position;
                    desc_next.res2 = second_residue;
                    mismatch_next  = 1'b0;
                    count_next     = '0;
                end
                default:
                begin
                    seed_len_next = seed_len_reg;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = kind_reg;
    assign out_residue  = res_reg;
    assign out_position = opos_reg;
    assign out_length   = olen_reg;
    assign out_last     = olast_reg;
    assign matched      = match_reg;

    `SVAC_ASSERT_NOW(a_issue_slot, iss_valid, !s1_v_reg || advance,
        "read issued into an occupied stage")
    `SVAC_ASSERT_NOW(a_no_accept_in_emit, busy, !in_ready,
        "request accepted during emit sweep")
    `SVAC_ASSERT_NOW(a_verdict_shape, out_valid_reg && kind_reg == svac_pkg::RK_VERDICT,
        olast_reg && res_reg == '0, "verdict without last mark or with residue")
    `SVAC_ASSERT_NEXT(a_edit_clears, accept && op == svac_pkg::OP_EDIT,
        !mismatch_reg && count_reg == '0, "set edit did not clear compare state")

endmodule

>>> tb/sv/tb_single_edit_variant_apply_check_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for single_edit_variant_apply_check_unit: seed loads, edits,
// emits and candidate compares, each result checked against an in-bench sequence model.
// Depends on svac_pkg and the unit RTL.
module tb_single_edit_variant_apply_check_unit;
    import svac_pkg::*;

    localparam int SEED_DEPTH     = DEF_MAX_SEQ_LEN;
    localparam int RES_MAX        = (1 << RES_W) - 1;
    localparam int POS2_MAX       = (1 << POS2_W) - 1;
    localparam int KIND_MAX       = (1 << KIND_W) - 1;
    localparam int CAND_COUNT_MAX = 63;
    localparam int STALL_CYCLES   = 200;
    localparam int WATCHDOG_LIMIT = 1500;
    localparam int TAIL_CYCLES    = 20;

    // kinds beyond double substitution behave as identical
    localparam logic [KIND_W-1:0] EK_UNUSED_MIN = 3'd5;
    localparam logic [KIND_W-1:0] EK_UNUSED_MAX = 3'd7;

    typedef enum int {
        CAND_EXACT,
        CAND_BAD_RESIDUE,
        CAND_SHORT,
        CAND_LONG,
        CAND_SKIP
    } cand_shape_t;

    typedef struct {
        op_t               op;
        logic [POS_W-1:0]  pos;
        logic [RES_W-1:0]  res;
        logic              fin;
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  p1;
        logic [RES_W-1:0]  r1;
        logic [POS2_W-1:0] p2;
        logic [RES_W-1:0]  r2;
    } request_t;

    typedef struct {
        logic             kind;
        logic [RES_W-1:0] residue;
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] length;
        logic             is_last;
        logic             matched;
    } variant_result_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         opcode;
    logic [POS_W-1:0]   position;
    logic [RES_W-1:0]   residue;
    logic               last_flag;
    logic [KIND_W-1:0]  edit_kind;
    logic [POS_W-1:0]   first_position;
    logic [RES_W-1:0]   first_residue;
    logic [POS2_W-1:0]  second_position;
    logic [RES_W-1:0]   second_residue;
    logic               out_valid;
    logic               out_ready;
    logic               result_kind;
    logic [RES_W-1:0]   out_residue;
    logic [POS_W-1:0]   out_position;
    logic [POS_W-1:0]   out_length;
    logic               out_last;
    logic               matched;

    // model state
    logic [RES_W-1:0]   seed_copy [0:SEED_DEPTH-1];
    logic [POS_W-1:0]   seed_len;
    edit_t              cur_edit;
    logic               cand_mismatch;
    logic [POS_W-1:0]   cand_count;

    variant_result_t    pending_results [$];

    int send_idle_pct    = 0;
    int recv_idle_pct    = 0;
    int hold_request     = 0;
    int quiet_cycles     = 0;
    int error_count      = 0;
    int sent_count       = 0;
    int residues_checked = 0;
    int verdicts_checked = 0;
    int verdicts_matched = 0;

    single_edit_variant_apply_check_unit i_dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .position        (position),
        .residue         (residue),
        .last_flag       (last_flag),
        .edit_kind       (edit_kind),
        .first_position  (first_position),
        .first_residue   (first_residue),
        .second_position (second_position),
        .second_residue  (second_residue),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .result_kind     (result_kind),
        .out_residue     (out_residue),
        .out_position    (out_position),
        .out_length      (out_length),
        .out_last        (out_last),
        .matched         (matched)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------- sequence model

    function automatic logic [RES_W-1:0] seed_residue(int idx);
        return (idx < SEED_DEPTH) ? seed_copy[idx] : '0;
    endfunction

    function automatic int edited_length();
        case (cur_edit.kind)
            EK_DEL:  return (seed_len != '0) ? int'(seed_len) - 1 : 0;
            EK_INS:  return int'(seed_len) + 1;
            default: return int'(seed_len);
        endcase
    endfunction

    function automatic logic [RES_W-1:0] edited_residue(int i);
        int p1;
        int p2;
        p1 = int'(cur_edit.pos1);
        p2 = int'(cur_edit.pos2);
        case (cur_edit.kind)
            EK_SUB:
                return (i == p1) ? cur_edit.res1 : seed_residue(i);
            EK_DEL:
                return (i < p1) ? seed_residue(i) : seed_residue(i + 1);
            EK_INS:
            begin
                if (i < p1)
                    return seed_residue(i);
                if (i == p1)
                    return cur_edit.res1;
                return seed_residue(i - 1);
            end
            EK_DSUB:
            begin
                if (i == p2)
                    return cur_edit.res2;
                if (i == p1)
                    return cur_edit.res1;
                return seed_residue(i);
            end
            default:
                return seed_residue(i);
        endcase
    endfunction

    // updates the model for one accepted request and queues the results it causes
    function automatic void predict_request_results(request_t r);
        variant_result_t v;
        int              n;
        int              p;
        n = edited_length();
        p = int'(r.pos);
        case (r.op)
            OP_LOAD:
            begin
                if (p < SEED_DEPTH)
                    seed_copy[p] = r.res;
                if (r.fin)
                    seed_len = (p < SEED_DEPTH) ? POS_W'(p + 1) : POS_W'(SEED_DEPTH);
            end
            OP_EDIT:
            begin
                cur_edit.kind = r.kind;
                cur_edit.pos1 = r.p1;
                cur_edit.res1 = r.r1;
                cur_edit.pos2 = r.p2;
                cur_edit.res2 = r.r2;
                cand_mismatch = 1'b0;
                cand_count    = '0;
            end
            OP_EMIT:
            begin
                for (int i = 0; i < n; i++)
                begin
                    v.kind     = RK_RESIDUE;
                    v.residue  = edited_residue(i);
                    v.position = POS_W'(i);
                    v.length   = POS_W'(n);
                    v.is_last  = (i == n - 1);
                    v.matched  = 1'b0;
                    pending_results.push_back(v);
                end
            end
            OP_CMP:
            begin
                if (p != int'(cand_count) || p >= n || r.res != edited_residue(p))
                    cand_mismatch = 1'b1;
                if (!r.fin)
                begin
                    if (int'(cand_count) < CAND_COUNT_MAX)
                        cand_count = cand_count + 1'b1;
                end
                else
                begin
                    v.kind     = RK_VERDICT;
                    v.residue  = '0;
                    v.position = r.pos;
                    v.length   = POS_W'(n);
                    v.is_last  = 1'b1;
                    v.matched  = !cand_mismatch && (p + 1 == n);
                    pending_results.push_back(v);
                    cand_mismatch = 1'b0;
                    cand_count    = '0;
                end
            end
        endcase
    endfunction

    // ---------------------------------------------------------------- request side

    function automatic request_t junk_request(op_t op);
        request_t r;
        r.op   = op;
        r.pos  = POS_W'($urandom_range(0, SEED_DEPTH));
        r.res  = RES_W'($urandom_range(0, RES_MAX));
        r.fin  = 1'($urandom_range(0, 1));
        r.kind = KIND_W'($urandom_range(0, KIND_MAX));
        r.p1   = POS_W'($urandom_range(0, SEED_DEPTH));
        r.r1   = RES_W'($urandom_range(0, RES_MAX));
        r.p2   = POS2_W'($urandom_range(0, POS2_MAX));
        r.r2   = RES_W'($urandom_range(0, RES_MAX));
        return r;
    endfunction

    // valid is left high on return; whoever pauses next lowers it
    task automatic send_request(request_t r);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        opcode          <= r.op;
        position        <= r.pos;
        residue         <= r.res;
        last_flag       <= r.fin;
        edit_kind       <= r.kind;
        first_position  <= r.p1;
        first_residue   <= r.r1;
        second_position <= r.p2;
        second_residue  <= r.r2;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_request_results(r);
        sent_count++;
    endtask

    task automatic send_load(int p, int res, bit fin);
        request_t r;
        r     = junk_request(OP_LOAD);
        r.pos = POS_W'(p);
        r.res = RES_W'(res);
        r.fin = fin;
        send_request(r);
    endtask

    task automatic send_edit(logic [KIND_W-1:0] kind, int p1, int r1, int p2, int r2);
        request_t r;
        r      = junk_request(OP_EDIT);
        r.kind = kind;
        r.p1   = POS_W'(p1);
        r.r1   = RES_W'(r1);
        r.p2   = POS2_W'(p2);
        r.r2   = RES_W'(r2);
        send_request(r);
    endtask

    task automatic send_emit();
        send_request(junk_request(OP_EMIT));
    endtask

    task automatic send_compare(int p, int res, bit fin);
        request_t r;
        r     = junk_request(OP_CMP);
        r.pos = POS_W'(p);
        r.res = RES_W'(res);
        r.fin = fin;
        send_request(r);
    endtask

    // candidate stream built from the current edited sequence, optionally spoilt
    task automatic send_candidate(cand_shape_t shape);
        int               n;
        int               cnt;
        int               bad;
        int               p;
        logic [RES_W-1:0] r;
        n   = edited_length();
        cnt = n;
        if (shape == CAND_SHORT)
            cnt = n - 1;
        if (shape == CAND_LONG && n <= SEED_DEPTH)
            cnt = n + 1;
        if (cnt < 1)
            cnt = 1;
        bad = $urandom_range(0, cnt - 1);
        for (int i = 0; i < cnt; i++)
        begin
            p = i;
            r = edited_residue(i);
            if (shape == CAND_BAD_RESIDUE && i == bad)
                r = r ^ RES_W'(1 << $urandom_range(0, RES_W - 1));
            if (shape == CAND_SKIP && i == bad)
                p = (i == 0) ? 1 : i - 1;
            send_compare(p, r, i == cnt - 1);
        end
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // ---------------------------------------------------------------- result side

    initial
    begin : result_receiver
        int stall_left;
        stall_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (stall_left != 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        variant_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request pending: kind %0d, position %0d",
                       result_kind, out_position);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("result_kind", want.kind, result_kind);
                check_field("out_residue", want.residue, out_residue);
                check_field("out_position", want.position, out_position);
                check_field("out_length", want.length, out_length);
                check_field("out_last", want.is_last, out_last);
                check_field("matched", want.matched, matched);
                if (want.kind == RK_VERDICT)
                begin
                    verdicts_checked++;
                    if (want.matched)
                        verdicts_matched++;
                end
                else
                    residues_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ---------------------------------------------------------------- tests

    // nothing loaded yet: edited length is zero, so no results
    task automatic test_reset_state();
        send_emit();
    endtask

    // every store entry gets written here, so later reads never hit an unwritten one
    task automatic test_seed_load_full();
        for (int i = 0; i < SEED_DEPTH; i++)
            send_load(i, (i == 0) ? 0 : (i == SEED_DEPTH - 1) ? RES_MAX
                                        : $urandom_range(0, RES_MAX),
                      i == SEED_DEPTH - 1);
        send_emit();
    endtask

    task automatic test_insert_extremes();
        // write beyond the store is dropped, length pinned at the store size
        send_load(SEED_DEPTH, RES_MAX, 1);
        send_edit(EK_INS, SEED_DEPTH, RES_MAX, 0, 0);
        send_emit();
        send_edit(EK_DSUB, 0, RES_MAX, POS2_MAX, 0);
        send_emit();
    endtask

    task automatic test_short_edits();
        // deletion from a one-residue seed leaves nothing to emit
        send_load(0, $urandom_range(0, RES_MAX), 1);
        send_edit(EK_DEL, 0, 0, 0, 0);
        send_emit();
        send_compare(0, 0, 1);
        send_load(3, $urandom_range(0, RES_MAX), 1);
        send_edit(EK_SUB, 0, RES_MAX, 0, 0);
        send_emit();
        // substitution past the end changes nothing
        send_edit(EK_SUB, 20, 0, 0, 0);
        send_emit();
        send_edit(EK_UNUSED_MAX, 1, RES_MAX, 2, RES_MAX);
        send_emit();
        send_edit(EK_DEL, 1, 0, 0, 0);
        send_emit();
        send_edit(EK_INS, 2, 7, 0, 0);
        send_emit();
    endtask

    task automatic test_candidate_checks();
        send_edit(EK_DSUB, 1, $urandom_range(0, RES_MAX), 3, $urandom_range(0, RES_MAX));
        send_candidate(CAND_EXACT);
        send_candidate(CAND_BAD_RESIDUE);
        send_candidate(CAND_SHORT);
        send_candidate(CAND_LONG);
        send_candidate(CAND_SKIP);
        send_edit(EK_UNUSED_MIN, 0, 0, 0, 0);
        send_candidate(CAND_EXACT);
    endtask

    task automatic random_round();
        int                n;
        int                k;
        int                p1;
        int                p2;
        logic [KIND_W-1:0] kind;
        case ($urandom_range(0, 11))
            0, 1:
            begin
                // fresh seed: a few scattered writes, then the closing residue sets the length
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, SEED_DEPTH)
                                                : $urandom_range(1, 8);
                k = $urandom_range(0, 3);
                repeat (k)
                    send_load($urandom_range(0, n - 1), $urandom_range(0, RES_MAX), 0);
                send_load(n - 1, $urandom_range(0, RES_MAX), 1);
            end
            2, 3:
            begin
                n    = int'(seed_len);
                kind = KIND_W'($urandom_range(EK_SAME, EK_DSUB));
                p1   = $urandom_range(0, (n > 0) ? n - 1 : 0);
                p2   = $urandom_range(0, POS2_MAX);
                if (kind == EK_INS)
                    p1 = $urandom_range(0, n);
                if (kind == EK_DSUB)
                begin
                    if (n < 2)
                        kind = EK_SUB;
                    else
                    begin
                        p1 = $urandom_range(0, n - 2);
                        p2 = $urandom_range(p1 + 1, n - 1);
                    end
                end
                send_edit(kind, p1, $urandom_range(0, RES_MAX), p2,
                          $urandom_range(0, RES_MAX));
            end
            4, 5:
                send_emit();
            6, 7, 8, 9:
                send_candidate(($urandom_range(0, 1) == 0) ? CAND_EXACT
                               : cand_shape_t'($urandom_range(CAND_BAD_RESIDUE, CAND_SKIP)));
            default:
                send_request(junk_request(op_t'($urandom_range(OP_LOAD, OP_CMP))));
        endcase
    endtask

    task automatic test_random_traffic(int sender_pct, int receiver_pct, int count);
        int stop_at;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        stop_at       = sent_count + count;
        while (sent_count < stop_at)
            random_round();
    endtask

    // results blocked for a long stretch while requests keep coming
    task automatic test_output_stall();
        send_load(7, $urandom_range(0, RES_MAX), 1);
        send_edit(EK_SUB, 3, $urandom_range(0, RES_MAX), 0, 0);
        hold_request = STALL_CYCLES;
        send_emit();
        send_candidate(CAND_EXACT);
        send_emit();
        send_candidate(CAND_SHORT);
    endtask

    task automatic test_drain_pause();
        send_candidate(CAND_BAD_RESIDUE);
        send_emit();
        wait_for_drain();
        send_emit();
        send_candidate(CAND_EXACT);
    endtask

    initial
    begin
        rst_n           <= 1'b0;
        in_valid        <= 1'b0;
        opcode          <= OP_LOAD;
        position        <= '0;
        residue         <= '0;
        last_flag       <= 1'b0;
        edit_kind       <= EK_SAME;
        first_position  <= '0;
        first_residue   <= '0;
        second_position <= '0;
        second_residue  <= '0;
        seed_len        = '0;
        cur_edit        = '0;
        cand_mismatch   = 1'b0;
        cand_count      = '0;
        for (int i = 0; i < SEED_DEPTH; i++)
            seed_copy[i] = '0;
        send_idle_pct = 19;
        recv_idle_pct = 69;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_seed_load_full();
        test_insert_extremes();
        test_short_edits();
        test_candidate_checks();
        test_random_traffic(19, 69, 15);
        test_random_traffic(69, 19, 15);
        test_random_traffic(0, 0, 15);
        test_output_stall();
        test_drain_pause();

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Covered %0d requests (loads, edits of every kind, emits, compares); %0d",
                 sent_count, residues_checked);
        $display("edited residues and %0d verdicts checked, %0d of them matches.",
                 verdicts_checked, verdicts_matched);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/svac_pkg.sv
rtl/svac_seed_mem.sv
rtl/svac_issue.sv
rtl/single_edit_variant_apply_check_unit.sv
tb/sv/tb_single_edit_variant_apply_check_unit.sv
